@@ design/svpl_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svpl_pkg: shared types and helpers for the servo position loop
// Transaction payloads, the internal job format, register codes and
// character helpers used by the front, the job queue and the back.
// ----------------------------------------------------------------------------
package svpl_pkg;

    // Default depth of the queue between front and back
    localparam int QUEUE_DEPTH_DEFAULT = 4;

    // Drive level limit and position range
    localparam logic [6:0]  DRIVE_MAX        = 7'd100;
    localparam logic [9:0]  POS_MAX          = 10'd1023;
    localparam logic [9:0]  ET_RESET         = 10'd100;
    localparam logic [11:0] WRAP_SPAN        = 12'd1024;
    localparam logic [3:0]  FULL_PACKET_LEN  = 4'd12;
    localparam logic [3:0]  MIN_PACKET_LEN   = 4'd4;

    // Packet character codes
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_UA    = 8'h41;
    localparam logic [7:0] CHAR_UF    = 8'h46;
    localparam logic [7:0] CHAR_LA    = 8'h61;
    localparam logic [7:0] CHAR_LF    = 8'h66;
    localparam logic [7:0] CHAR_UI    = 8'h49;
    localparam logic [7:0] CHAR_UL    = 8'h4C;

    // Register numbers of the packet port
    localparam logic [7:0] REG_TARGET   = 8'h00;
    localparam logic [7:0] REG_MODE     = 8'h01;
    localparam logic [7:0] REG_SPEED    = 8'h02;
    localparam logic [7:0] REG_LOCATION = 8'h06;
    localparam logic [7:0] REG_PWM      = 8'h07;

    // Item kinds
    localparam logic CMD_TICK = 1'b0;
    localparam logic CMD_CHAR = 1'b1;
    localparam logic KIND_DRIVE = 1'b0;
    localparam logic KIND_REPLY = 1'b1;

    typedef struct packed {
        logic       cmd;
        logic [9:0] position;
        logic [7:0] packet_char;
        logic       packet_last;
    } in_item_t;

    typedef struct packed {
        logic       kind;
        logic [6:0] drive_fwd;
        logic [6:0] drive_rev;
        logic [7:0] reply_char;
        logic       reply_last;
    } out_item_t;

    typedef enum logic [1:0] {
        JOB_DRIVE,
        JOB_FAIL,
        JOB_DATA
    } job_kind_t;

    // One unit of work handed from front to back
    typedef struct packed {
        job_kind_t   kind;
        logic [6:0]  fwd;
        logic [6:0]  rev;
        logic [31:0] data;
    } job_t;

    // ASCII hex character to digit; anything else reads as zero
    function automatic logic [3:0] hex_digit(input logic [7:0] c);
        logic [7:0] t;
        begin
            t = 8'd0;
            if (c >= CHAR_ZERO && c <= CHAR_NINE)
                t = c - CHAR_ZERO;
            else if (c >= CHAR_UA && c <= CHAR_UF)
                t = c - (CHAR_UA - 8'd10);
            else if (c >= CHAR_LA && c <= CHAR_LF)
                t = c - (CHAR_LA - 8'd10);
            return t[3:0];
        end
    endfunction

    // Nibble to uppercase ASCII hex
    function automatic logic [7:0] hex_char(input logic [3:0] n);
        begin
            if (n < 4'd10)
                return CHAR_ZERO + {4'd0, n};
            else
                return (CHAR_UA - 8'd10) + {4'd0, n};
        end
    endfunction

    // Letters of the failure reply
    function automatic logic [7:0] fail_char(input logic [1:0] i);
        begin
            case (i)
                2'd0:    return CHAR_UF;
                2'd1:    return CHAR_UA;
                2'd2:    return CHAR_UI;
                default: return CHAR_UL;
            endcase
        end
    endfunction

endpackage

@@ design/svpl_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svpl_front: item intake, control step and packet parser
// Takes one item per cycle while the queue has room, updates loop and
// register state, and posts a drive job per tick, a reply job at packet end.
// ----------------------------------------------------------------------------
module svpl_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  svpl_pkg::in_item_t in_data,
    output logic              push_valid,
    input  logic              push_ready,
    output svpl_pkg::job_t    push_job
);
    import svpl_pkg::*;

    logic [31:0] target_reg, target_next;
    logic [31:0] mode_reg, mode_next;
    logic [31:0] speed_reg, speed_next;
    logic [9:0]  loc_reg, loc_next;
    logic [9:0]  et_reg, et_next;
    logic [3:0]  count_reg, count_next;
    logic [8:0]  dev_reg, dev_next;
    logic [8:0]  regf_reg, regf_next;
    logic [32:0] val_reg, val_next;

    logic              accept;
    logic [3:0]        digit;
    logic              minus;
    logic [11:0]       delta;
    logic [11:0]       dist_mag;
    logic [6:0]        level;
    logic [7:0]        dev_val;
    logic [7:0]        reg_code;
    logic              reg_neg;
    logic [31:0]       data;
    logic              fail;
    job_t              job;

    assign in_ready = push_ready;
    assign accept   = in_valid && push_ready;
    assign digit    = hex_digit(in_data.packet_char);
    assign minus    = (in_data.packet_char == CHAR_MINUS);

    // Wrap-aware distance from effective target to the new position
    always_comb
    begin
        if (in_data.position[9:8] == 2'd0 && et_reg[9:8] == 2'd3)
            delta = {2'd0, in_data.position} + WRAP_SPAN - {2'd0, et_reg};
        else if (in_data.position[9:8] == 2'd3 && et_reg[9:8] == 2'd0)
            delta = {2'd0, in_data.position} - WRAP_SPAN - {2'd0, et_reg};
        else
            delta = {2'd0, in_data.position} - {2'd0, et_reg};
        dist_mag = delta[11] ? (12'd0 - delta) : delta;
        level    = (dist_mag > {5'd0, DRIVE_MAX}) ? DRIVE_MAX : dist_mag[6:0];
    end

    // Next state and job
    always_comb
    begin
        target_next = target_reg;
        mode_next   = mode_reg;
        speed_next  = speed_reg;
        loc_next    = loc_reg;
        et_next     = et_reg;
        count_next  = count_reg;
        dev_next    = dev_reg;
        regf_next   = regf_reg;
        val_next    = val_reg;
        dev_val     = 8'd0;
        reg_code    = 8'd0;
        reg_neg     = 1'b0;
        data        = 32'd0;
        fail        = 1'b0;
        job         = '0;
        push_valid  = 1'b0;

        if (accept && in_data.cmd == CMD_TICK)
        begin
            loc_next = in_data.position;
            job.kind = JOB_DRIVE;
            if (!delta[11] && delta != 12'd0)
                job.fwd = level;
            else
                job.rev = level;
            // effective target follows the target register, clamped
            if (target_reg[31])
                et_next = 10'd0;
            else if (|target_reg[30:10])
                et_next = POS_MAX;
            else
                et_next = target_reg[9:0];
            push_valid = 1'b1;
        end
        else if (accept)
        begin
            // shift the character into its field
            if (count_reg < 4'd2)
            begin
                dev_next[8]   = dev_reg[8] | (count_reg == 4'd0 && minus);
                dev_next[7:0] = {dev_reg[3:0], digit};
            end
            else if (count_reg < 4'd4)
            begin
                regf_next[8]   = regf_reg[8] | (count_reg == 4'd2 && minus);
                regf_next[7:0] = {regf_reg[3:0], digit};
            end
            else if (count_reg < FULL_PACKET_LEN)
            begin
                val_next[32]   = val_reg[32] | (count_reg == 4'd4 && minus);
                val_next[31:0] = {val_reg[27:0], digit};
            end
            if (count_reg < FULL_PACKET_LEN)
                count_next = count_reg + 4'd1;

            if (in_data.packet_last)
            begin
                dev_val  = dev_next[8] ? (8'd0 - dev_next[7:0]) : dev_next[7:0];
                reg_code = regf_next[7:0];
                reg_neg  = regf_next[8] && (regf_next[7:0] != 8'd0);
                if (count_next >= FULL_PACKET_LEN)
                    data = val_next[32] ? (32'd0 - val_next[31:0]) : val_next[31:0];

                if (count_next < MIN_PACKET_LEN || reg_neg)
                    fail = 1'b1;
                else if (dev_val[7])
                begin
                    unique case (reg_code)
                        REG_TARGET: target_next = data;
                        REG_MODE:   mode_next   = data;
                        REG_SPEED:  speed_next  = data;
                        default:    fail        = 1'b1;
                    endcase
                end
                else
                begin
                    unique case (reg_code)
                        REG_TARGET:   data = target_reg;
                        REG_MODE:     data = mode_reg;
                        REG_SPEED:    data = speed_reg;
                        REG_LOCATION: data = {22'd0, loc_reg};
                        REG_PWM:      data = 32'd0;
                        default:      fail = 1'b1;
                    endcase
                end

                job.kind   = fail ? JOB_FAIL : JOB_DATA;
                job.data   = data;
                push_valid = 1'b1;

                // packet done: parse state back to idle
                count_next = 4'd0;
                dev_next   = 9'd0;
                regf_next  = 9'd0;
                val_next   = 33'd0;
            end
        end
    end

    assign push_job = job;

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg <= 32'd0;
            mode_reg   <= 32'd0;
            speed_reg  <= 32'd0;
            loc_reg    <= 10'd0;
            et_reg     <= ET_RESET;
            count_reg  <= 4'd0;
            dev_reg    <= 9'd0;
            regf_reg   <= 9'd0;
            val_reg    <= 33'd0;
        end
        else
        begin
            target_reg <= target_next;
            mode_reg   <= mode_next;
            speed_reg  <= speed_next;
            loc_reg    <= loc_next;
            et_reg     <= et_next;
            count_reg  <= count_next;
            dev_reg    <= dev_next;
            regf_reg   <= regf_next;
            val_reg    <= val_next;
        end
    end

endmodule

@@ design/svpl_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svpl_queue: job queue between front and back
// Small circular buffer of jobs with a fill count.
// ----------------------------------------------------------------------------
module svpl_queue #(
    parameter int DEPTH = svpl_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push_valid,
    output logic           push_ready,
    input  svpl_pkg::job_t push_job,
    output logic           pop_valid,
    input  logic           pop_ready,
    output svpl_pkg::job_t pop_job
);
    import svpl_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    job_t          mem [DEPTH];
    logic [AW-1:0] wptr_reg, rptr_reg;
    logic [CW-1:0] count_reg;
    logic          do_push, do_pop;

    assign push_ready = (count_reg != CW'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_job    = mem[rptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // Storage
    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wptr_reg] <= push_job;
    end

    // Pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (do_push)
                wptr_reg <= (wptr_reg == AW'(DEPTH - 1)) ? '0 : wptr_reg + 1'b1;
            if (do_pop)
                rptr_reg <= (rptr_reg == AW'(DEPTH - 1)) ? '0 : rptr_reg + 1'b1;
            if (do_push && !do_pop)
                count_reg <= count_reg + 1'b1;
            else if (do_pop && !do_push)
                count_reg <= count_reg - 1'b1;
        end
    end

endmodule

@@ design/svpl_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svpl_back: result sequencer
// Holds the current job and emits its results one per transaction: one drive
// update, four letters of a failure, or eight hex characters of a value.
// ----------------------------------------------------------------------------
module svpl_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                pop_valid,
    output logic                pop_ready,
    input  svpl_pkg::job_t      pop_job,
    output logic                out_valid,
    input  logic                out_ready,
    output svpl_pkg::out_item_t out_data
);
    import svpl_pkg::*;

    job_t        job_reg;
    logic        busy_reg;
    logic [2:0]  idx_reg;
    logic        run_last;
    logic        load;
    logic [31:0] shifted;
    out_item_t   res;

    // Last result of the current job
    always_comb
    begin
        case (job_reg.kind)
            JOB_FAIL: run_last = (idx_reg == 3'd3);
            JOB_DATA: run_last = (idx_reg == 3'd7);
            default:  run_last = 1'b1;
        endcase
    end

    assign out_valid = busy_reg;
    assign load      = pop_valid && (!busy_reg || (out_ready && run_last));
    assign pop_ready = !busy_reg || (out_ready && run_last);
    assign shifted   = job_reg.data << {idx_reg, 2'b00};

    // Result formatting
    always_comb
    begin
        res = '0;
        case (job_reg.kind)
            JOB_DRIVE:
            begin
                res.kind      = KIND_DRIVE;
                res.drive_fwd = job_reg.fwd;
                res.drive_rev = job_reg.rev;
            end
            JOB_FAIL:
            begin
                res.kind       = KIND_REPLY;
                res.reply_char = fail_char(idx_reg[1:0]);
                res.reply_last = run_last;
            end
            default:
            begin
                res.kind       = KIND_REPLY;
                res.reply_char = hex_char(shifted[31:28]);
                res.reply_last = run_last;
            end
        endcase
    end

    assign out_data = res;

    // Job register and character index
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            idx_reg  <= 3'd0;
            job_reg  <= '0;
        end
        else if (load)
        begin
            busy_reg <= 1'b1;
            idx_reg  <= 3'd0;
            job_reg  <= pop_job;
        end
        else if (busy_reg && out_ready)
        begin
            if (run_last)
                busy_reg <= 1'b0;
            else
                idx_reg <= idx_reg + 3'd1;
        end
    end

    // A drive job never advances past its single result
    a_drive_single: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg && job_reg.kind == JOB_DRIVE |-> idx_reg == 3'd0)
        else $error("drive job index advanced");

    // A failure reply stays within its four letters
    a_fail_len: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg && job_reg.kind == JOB_FAIL |-> idx_reg <= 3'd3)
        else $error("failure reply overran");

    // A reply run keeps going until its last character is taken
    a_run_cont: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !run_last |=> out_valid && idx_reg == $past(idx_reg) + 3'd1)
        else $error("reply run broken");

endmodule

@@ design/servo_position_loop_hex_register_port.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// servo_position_loop_hex_register_port: servo loop with hex register port
// Control ticks produce a forward/reverse drive update toward the target;
// packet characters build hex commands that write or read registers and
// answer with an eight-character hex reply or FAIL.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+---------------------
//   in      | input     | in_valid / in_ready   | in_data  (in_item_t)
//   out     | output    | out_valid / out_ready | out_data (out_item_t)
//
// The front takes one item per cycle while the job queue has room; a job is
// written into the queue on accept, loaded into the back's job register once
// the back is free, and shown on the output from that register. The back
// gives one result per cycle while out_ready is high: 1 for a tick, 4 or 8 for
// a packet end, so reply bursts set the sustained rate; the queue absorbs
// ticks meanwhile.
// Reset clears all state but the queue storage; the effective target starts at 100.
// A stalled output only holds the back; the front keeps accepting until the
// queue is full.
// ----------------------------------------------------------------------------
module servo_position_loop_hex_register_port #(
    parameter int QUEUE_DEPTH = svpl_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  svpl_pkg::in_item_t  in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output svpl_pkg::out_item_t out_data
);
    import svpl_pkg::*;

    logic push_valid, push_ready;
    logic pop_valid, pop_ready;
    job_t push_job, pop_job;

    svpl_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_data    (in_data),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_job   (push_job)
    );

    svpl_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_job   (push_job),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_job    (pop_job)
    );

    svpl_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_job   (pop_job),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

@@ bench/servo_position_loop_hex_register_port_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// servo_position_loop_hex_register_port_tb: testbench for the servo loop
// A scoreboard class tracks the servo registers, the drive target and the
// packet parser, and predicts each drive update and reply character. Plain
// tasks send directed ticks and packets, then random ticks, packets with random
// content, length and noise, and raw character noise, under several idle and
// stall profiles, including one long output hold that backs up the block.
// ----------------------------------------------------------------------------
module servo_position_loop_hex_register_port_tb;

    import svpl_pkg::*;

    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 20;
    localparam int RUN_LIMIT_NS = 4_000_000;

    // Servo register and packet parser tracking, expected results in order
    class servo_scoreboard;
        logic [31:0] target_reg;
        logic [31:0] mode_reg;
        logic [31:0] speed_reg;
        logic [9:0]  location;
        logic [9:0]  eff_target;
        int unsigned char_cnt;
        logic        dev_neg;
        logic        reg_neg;
        logic        val_neg;
        logic [7:0]  dev_mag;
        logic [7:0]  reg_mag;
        logic [31:0] val_mag;
        out_item_t   expected_q[$];
        int unsigned errors;

        function new();
            target_reg = '0;
            mode_reg   = '0;
            speed_reg  = '0;
            location   = '0;
            eff_target = ET_RESET;
            char_cnt   = 0;
            dev_neg    = 1'b0;
            reg_neg    = 1'b0;
            val_neg    = 1'b0;
            dev_mag    = '0;
            reg_mag    = '0;
            val_mag    = '0;
            errors     = 0;
        endfunction

        // Nibble as ASCII hex, either case
        static function logic [7:0] nibble_text(input logic [3:0] n, input bit lower);
            if (n < 4'd10)
                return CHAR_ZERO + n;
            return (lower ? CHAR_LA : CHAR_UA) + n - 8'd10;
        endfunction

        function void push_reply(input logic [7:0] c, input logic last);
            out_item_t r;
            r = {KIND_REPLY, 7'd0, 7'd0, c, last};
            expected_q.push_back(r);
        endfunction

        // Update the model with one accepted input transaction
        function void note_input(input in_item_t item);
            int          pos_i;
            int          tgt_i;
            int          span;
            int          limit;
            int          delta;
            int          k;
            logic [6:0]  fwd;
            logic [6:0]  rev;
            logic [7:0]  c;
            logic [3:0]  digit;
            logic [31:0] dev_w;
            logic [31:0] reg_w;
            logic [31:0] data;
            bit          minus;
            bit          fail;
            out_item_t   drive;

            if (item.cmd == CMD_TICK) begin
                // drive step toward the current target, across the rollover if needed
                location = item.position;
                pos_i = location;
                tgt_i = eff_target;
                span  = WRAP_SPAN;
                limit = DRIVE_MAX;
                if (location[9:8] == 2'd0 && eff_target[9:8] == 2'd3)
                    delta = pos_i + span - tgt_i;
                else if (location[9:8] == 2'd3 && eff_target[9:8] == 2'd0)
                    delta = pos_i - span - tgt_i;
                else
                    delta = pos_i - tgt_i;
                fwd = '0;
                rev = '0;
                if (delta > 0)
                    fwd = 7'((delta > limit) ? limit : delta);
                else
                    rev = 7'((-delta > limit) ? limit : -delta);

                // target register, signed, clamped to the position range
                if (target_reg[31])
                    eff_target = '0;
                else if (target_reg > POS_MAX)
                    eff_target = POS_MAX;
                else
                    eff_target = target_reg[9:0];

                drive = {KIND_DRIVE, fwd, rev, 8'd0, 1'b0};
                expected_q.push_back(drive);
            end else begin
                // shift one character into the field it belongs to
                c = item.packet_char;
                minus = (c == CHAR_MINUS);
                digit = '0;
                if (c >= CHAR_ZERO && c <= CHAR_NINE)
                    digit = c[3:0];
                else if ((c >= CHAR_UA && c <= CHAR_UF) || (c >= CHAR_LA && c <= CHAR_LF))
                    digit = c[3:0] + 4'd9;

                if (char_cnt < 2) begin
                    if (char_cnt == 0 && minus)
                        dev_neg = 1'b1;
                    dev_mag = {dev_mag[3:0], digit};
                end else if (char_cnt < MIN_PACKET_LEN) begin
                    if (char_cnt == 2 && minus)
                        reg_neg = 1'b1;
                    reg_mag = {reg_mag[3:0], digit};
                end else if (char_cnt < FULL_PACKET_LEN) begin
                    if (char_cnt == MIN_PACKET_LEN && minus)
                        val_neg = 1'b1;
                    val_mag = {val_mag[27:0], digit};
                end
                if (char_cnt < FULL_PACKET_LEN)
                    char_cnt++;

                if (item.packet_last) begin
                    // end of packet: register access and reply
                    fail = 1'b0;
                    data = '0;
                    if (char_cnt < MIN_PACKET_LEN) begin
                        fail = 1'b1;
                    end else begin
                        dev_w = {24'd0, dev_mag};
                        if (dev_neg)
                            dev_w = -dev_w;
                        reg_w = {24'd0, reg_mag};
                        if (reg_neg)
                            reg_w = -reg_w;
                        if (char_cnt >= FULL_PACKET_LEN)
                            data = val_neg ? -val_mag : val_mag;
                        if (dev_w[7]) begin
                            if (reg_w == {24'd0, REG_TARGET})
                                target_reg = data;
                            else if (reg_w == {24'd0, REG_MODE})
                                mode_reg = data;
                            else if (reg_w == {24'd0, REG_SPEED})
                                speed_reg = data;
                            else
                                fail = 1'b1;
                        end else begin
                            if (reg_w == {24'd0, REG_TARGET})
                                data = target_reg;
                            else if (reg_w == {24'd0, REG_MODE})
                                data = mode_reg;
                            else if (reg_w == {24'd0, REG_SPEED})
                                data = speed_reg;
                            else if (reg_w == {24'd0, REG_LOCATION})
                                data = {22'd0, location};
                            else if (reg_w == {24'd0, REG_PWM})
                                data = '0;
                            else
                                fail = 1'b1;
                        end
                    end

                    char_cnt = 0;
                    dev_neg  = 1'b0;
                    reg_neg  = 1'b0;
                    val_neg  = 1'b0;
                    dev_mag  = '0;
                    reg_mag  = '0;
                    val_mag  = '0;

                    if (fail) begin
                        push_reply(CHAR_UF, 1'b0);
                        push_reply(CHAR_UA, 1'b0);
                        push_reply(CHAR_UI, 1'b0);
                        push_reply(CHAR_UL, 1'b1);
                    end else begin
                        for (k = 0; k < 8; k++)
                            push_reply(nibble_text(data[31 - 4 * k -: 4], 1'b0), k == 7);
                    end
                end
            end
        endfunction

        function void compare_field(input string name, input int unsigned want_v,
                                    input int unsigned got_v);
            if (want_v != got_v) begin
                errors++;
                $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
                         $time, name, want_v, got_v);
            end
        endfunction

        // Compare one accepted output transaction with the oldest expectation
        function void check_result(input out_item_t got);
            out_item_t want;
            if (expected_q.size() == 0) begin
                errors++;
                $display("%0t: unexpected result, expected none, actual 0x%h", $time, got);
                return;
            end
            want = expected_q.pop_front();
            compare_field("kind", want.kind, got.kind);
            compare_field("drive_fwd", want.drive_fwd, got.drive_fwd);
            compare_field("drive_rev", want.drive_rev, got.drive_rev);
            compare_field("reply_char", want.reply_char, got.reply_char);
            compare_field("reply_last", want.reply_last, got.reply_last);
        endfunction
    endclass

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_ready;
    in_item_t   in_data = '0;
    logic       out_valid;
    logic       out_ready = 1'b0;
    out_item_t  out_data;

    servo_scoreboard sb = new();

    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    int unsigned items_sent = 0;
    int          hold_req = 0;
    int          hold_ack = 0;
    int          hold_cnt = 0;
    logic [7:0]  text_buf[$];

    servo_position_loop_hex_register_port u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    always #2 clk = ~clk;

    // Output side: check accepted results, then pick next ready (hold or random stall)
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_result(out_data);
        if (hold_cnt != 0) begin
            out_ready <= 1'b0;
            hold_cnt  <= hold_cnt - 1;
        end else if (hold_req != hold_ack) begin
            out_ready <= 1'b0;
            hold_ack  <= hold_req;
            hold_cnt  <= HOLD_CYCLES;
        end else begin
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Run time limit
    initial
    begin
        #(RUN_LIMIT_NS);
        $display("Test completed with failures");
        $finish;
    end

    function automatic logic [9:0] random_position();
        if ($urandom_range(3) == 0) begin
            case ($urandom_range(5))
                0:       return 10'd0;
                1:       return 10'd255;
                2:       return 10'd256;
                3:       return 10'd767;
                4:       return 10'd768;
                default: return POS_MAX;
            endcase
        end
        return $urandom_range(1023);
    endfunction

    // Offer one input transaction, with an optional idle gap, and wait for accept
    task automatic send_item(input in_item_t item);
        if ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < send_idle_pct)
                @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sb.note_input(item);
        items_sent++;
    endtask

    task automatic send_tick(input logic [9:0] pos);
        in_item_t item;
        item.cmd         = CMD_TICK;
        item.position    = pos;
        item.packet_char = $urandom_range(255);
        item.packet_last = $urandom_range(1);
        send_item(item);
    endtask

    task automatic send_char(input logic [7:0] c, input logic last);
        in_item_t item;
        item.cmd         = CMD_CHAR;
        item.position    = $urandom_range(1023);
        item.packet_char = c;
        item.packet_last = last;
        send_item(item);
    endtask

    // Send text_buf as one packet, last flag on the final character
    task automatic send_text(input bit mix_ticks);
        int i;
        for (i = 0; i < text_buf.size(); i++) begin
            if (mix_ticks && $urandom_range(9) == 0)
                send_tick(random_position());
            send_char(text_buf[i], i == text_buf.size() - 1);
        end
    endtask

    task automatic send_string(input string s);
        int i;
        text_buf.delete();
        for (i = 0; i < s.len(); i++)
            text_buf.push_back(s[i]);
        send_text(1'b0);
    endtask

    // Packet with random device, register and value, random length and noise
    task automatic random_packet();
        logic [7:0]  dev;
        logic [7:0]  regn;
        logic [31:0] val;
        logic [47:0] fields;
        int          len;
        int          r;
        int          i;

        dev = $urandom_range(255);
        case ($urandom_range(5))
            0:       regn = REG_TARGET;
            1:       regn = REG_MODE;
            2:       regn = REG_SPEED;
            3:       regn = REG_LOCATION;
            4:       regn = REG_PWM;
            default: regn = $urandom_range(255);
        endcase
        r = $urandom_range(99);
        if (r < 50)
            val = $urandom_range(1100);
        else if (r < 80)
            val = $urandom;
        else begin
            case ($urandom_range(4))
                0:       val = 32'h8000_0000;
                1:       val = 32'hFFFF_FFFF;
                2:       val = 32'd1023;
                3:       val = 32'd1024;
                default: val = 32'h7FFF_FFFF;
            endcase
        end

        fields = {dev, regn, val};
        text_buf.delete();
        for (i = 0; i < 12; i++)
            text_buf.push_back(servo_scoreboard::nibble_text(fields[47 - 4 * i -: 4],
                                                             $urandom_range(1)));
        // negated fields
        if ($urandom_range(99) < 15)
            text_buf[0] = CHAR_MINUS;
        if ($urandom_range(99) < 15)
            text_buf[2] = CHAR_MINUS;
        if ($urandom_range(99) < 15)
            text_buf[4] = CHAR_MINUS;

        // length: short, bare, partial value, full, or overlong
        r = $urandom_range(99);
        if (r < 8)
            len = $urandom_range(1, 3);
        else if (r < 20)
            len = 4;
        else if (r < 35)
            len = $urandom_range(5, 11);
        else if (r < 90)
            len = 12;
        else
            len = $urandom_range(13, 15);
        while (text_buf.size() > len)
            void'(text_buf.pop_back());
        while (text_buf.size() < len)
            text_buf.push_back($urandom_range(255));

        // occasional non-hex characters
        for (i = 0; i < len; i++)
            if ($urandom_range(99) < 4)
                text_buf[i] = $urandom_range(255);

        send_text(1'b1);
    endtask

    // Raw character noise, closed by a last-marked character
    task automatic random_noise();
        int n;
        int i;
        n = $urandom_range(1, 6);
        for (i = 0; i < n; i++)
            send_char($urandom_range(255), (i == n - 1) || ($urandom_range(3) == 0));
    endtask

    task automatic run_phase(input int idle_pct, input int stall_pct, input int count);
        int unsigned goal;
        int          r;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        goal = items_sent + count;
        while (items_sent < goal) begin
            r = $urandom_range(99);
            if (r < 30)
                send_tick(random_position());
            else if (r < 88)
                random_packet();
            else
                random_noise();
        end
    endtask

    // Main sequence
    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: wrap and clamp cases, register access, short and negated packets
        send_tick(POS_MAX);
        send_tick(10'd0);
        send_tick(10'd150);
        send_string("800000000380");
        send_tick(10'd5);
        send_tick(10'd5);
        send_tick(10'd900);
        send_string("0006");
        send_string("8-");
        send_string("-1-0");
        send_string("0Gx1");

        // Random traffic under each idle and stall profile
        run_phase(0, 0, 110);
        run_phase(88, 0, 70);
        run_phase(0, 88, 70);
        run_phase(20, 20, 100);

        // Long output hold while the input keeps offering
        hold_req <= hold_req + 1;
        run_phase(0, 0, 60);
        run_phase(0, 0, 40);

        in_valid <= 1'b0;
        while (sb.expected_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (sb.errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

@@ sim.f @@
design/svpl_pkg.sv
design/svpl_front.sv
design/svpl_queue.sv
design/svpl_back.sv
design/servo_position_loop_hex_register_port.sv
bench/servo_position_loop_hex_register_port_tb.sv
